// ----- sv/mab_pkg.sv -----
// ---------------------------------------------------------------------------
// mab_pkg
// types and constants shared by the band signal block and its interfaces
// ---------------------------------------------------------------------------
package mab_pkg;

  // payload widths
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned AVG_W    = 48;
  localparam int unsigned DAYS_W   = 7;
  localparam int unsigned BAND_W   = 16;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // average and reference carry 16 more fraction bits than the price
  localparam int unsigned AVG_SHIFT = 16;

  typedef logic [PRICE_W-1:0]  price_t;
  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [PRICE_W-1:0]  level_t;
  typedef logic [AVG_W-1:0]    avg_t;
  typedef logic [DAYS_W-1:0]   days_t;
  typedef logic [BAND_W-1:0]   band_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [DATA_W-1:0]   data_t;

  // action codes
  localparam action_t ACT_NONE = 2'd0;
  localparam action_t ACT_SELL = 2'd1;
  localparam action_t ACT_BUY  = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_BUY    = 2'd1;
  localparam logic [1:0] REG_SELL   = 2'd2;

  // register reset values and window clamp
  localparam days_t DAYS_MIN   = 7'd20;
  localparam days_t DAYS_MAX   = 7'd120;
  localparam band_t BAND_RESET = 16'd655;

  // divider step counts
  localparam logic [5:0] AVG_DIV_STEPS = 6'd48;
  localparam logic [5:0] WT_DIV_STEPS  = 6'd16;

endpackage

// ----- sv/mab_in_if.sv -----
// ---------------------------------------------------------------------------
// mab_in_if
// input channel: one closing price per word
// ---------------------------------------------------------------------------
interface mab_in_if;
  logic            valid;
  logic            ready;
  mab_pkg::price_t price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

// ----- sv/mab_out_if.sv -----
// ---------------------------------------------------------------------------
// mab_out_if
// result channel: action, buy weight and band level per word
// ---------------------------------------------------------------------------
interface mab_out_if;
  logic             valid;
  logic             ready;
  mab_pkg::action_t action;
  mab_pkg::weight_t buy_weight;
  mab_pkg::level_t  band_level;

  modport source (output valid, output action, output buy_weight, output band_level,
                  input ready);
  modport sink   (input valid, input action, input buy_weight, input band_level,
                  output ready);
endinterface

// ----- sv/moving_average_band_signal_top.sv -----
// ---------------------------------------------------------------------------
// moving_average_band_signal_top
// moving average with trailing max/min band crossover, one price series
// ---------------------------------------------------------------------------
//  port       dir   handshake          payload
//  in_chan    in    valid/ready        price (Q16.16, zero = no quote)
//  out_chan   out   valid/ready        action, buy_weight, band_level
//  apb        in    psel/penable       window_days, buy_band, sell_band
//
//  a zero price goes from accept straight to the band product, a nonzero
//  price first passes the shared 48x17 multiplier and the one-bit-per-cycle
//  restoring divider (48 steps for the average, 16 for the buy weight)
//  one word is in flight at a time; the input is ready again as soon as the
//  result sits in the output register, even while that result is stalled
//  reset (rst_n low, synchronous) restores the register defaults, sell mode
//  and a zero average, reference and warm-up count
// ---------------------------------------------------------------------------
module moving_average_band_signal_top (
  input  logic            clk,
  input  logic            rst_n,
  mab_in_if.sink          in_chan,
  mab_out_if.source       out_chan,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  mab_pkg::addr_t  paddr,
  input  mab_pkg::data_t  pwdata,
  output mab_pkg::data_t  prdata,
  output logic            pready
);
  import mab_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MAVG  = 9'b000000010,
    S_DSET  = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_UPD   = 9'b000010000,
    S_MREF  = 9'b000100000,
    S_TEST  = 9'b001000000,
    S_MBAND = 9'b010000000,
    S_BAND  = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;

  // configuration
  days_t       window_r;
  band_t       buy_band_r;
  band_t       sell_band_r;

  // series state
  logic        selling_r;
  avg_t        average_r;
  days_t       warm_cnt_r;
  avg_t        ref_r;

  // per-word working registers
  price_t      price_r;
  logic        warm_r;
  logic [63:0] prod_r;
  action_t     act_r;
  weight_t     wt_r;

  // shared divider
  logic [48:0] rem_r;
  logic [47:0] quo_r;
  logic [48:0] dvs_r;
  logic [5:0]  div_cnt_r;
  logic        div_wt_r;

  // output register
  logic        out_valid_r;
  action_t     out_action_r;
  weight_t     out_weight_r;
  level_t      out_level_r;

  // apb write and read decode
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW: prdata = {25'd0, window_r};
      REG_BUY:    prdata = {16'd0, buy_band_r};
      REG_SELL:   prdata = {16'd0, sell_band_r};
      default:    prdata = '0;
    endcase
  end

  // clamped window and its derived values
  days_t days_eff;
  days_t days_m1;
  always_comb begin
    if (window_r < DAYS_MIN) begin
      days_eff = DAYS_MIN;
    end else if (window_r > DAYS_MAX) begin
      days_eff = DAYS_MAX;
    end else begin
      days_eff = window_r;
    end
    days_m1 = days_eff - 7'd1;
  end

  // price in average format and with 32 more fraction bits
  avg_t        qa;
  logic [63:0] qx;
  assign qa = {price_r, 16'd0};
  assign qx = {price_r, 32'd0};

  // shared multiplier
  logic [47:0] mul_a;
  logic [16:0] mul_b;
  logic [64:0] mul_p;
  logic [16:0] band_fac;
  assign band_fac = selling_r ? (17'h10000 - {1'b0, sell_band_r}) : {1'b0, buy_band_r};

  always_comb begin
    if (state_r == S_MAVG) begin
      mul_a = average_r;
      mul_b = warm_r ? {10'd0, warm_cnt_r} : {10'd0, days_m1};
    end else begin
      mul_a = ref_r;
      mul_b = band_fac;
    end
    mul_p = {17'd0, mul_a} * {48'd0, mul_b};
  end

  // divider setup for the average update
  logic [55:0] num;
  assign num = prod_r[55:0] + {8'd0, qa};

  // one restoring divider step
  logic [49:0] div_sh;
  logic        div_ge;
  logic [48:0] rem_step;
  logic [47:0] quo_step;
  always_comb begin
    div_sh   = {rem_r, quo_r[47]};
    div_ge   = div_sh >= {1'b0, dvs_r};
    rem_step = div_ge ? 49'(div_sh - {1'b0, dvs_r}) : div_sh[48:0];
    quo_step = {quo_r[46:0], div_ge};
  end

  // trailing max/min of the new average
  avg_t ref_track;
  always_comb begin
    if (selling_r) begin
      ref_track = (quo_r > ref_r) ? quo_r : ref_r;
    end else begin
      ref_track = (quo_r < ref_r) ? quo_r : ref_r;
    end
  end

  // trigger tests on the registered product
  logic        sell_hit;
  logic        buy_hit;
  logic [48:0] lr;
  logic [48:0] wd;
  assign sell_hit = qx <= prod_r;
  assign buy_hit  = (prod_r <= qx) && ((qx - prod_r) >= {ref_r, 16'd0});
  assign lr       = {1'b0, ref_r} + {1'b0, prod_r[63:16]};
  assign wd       = {1'b0, qa} - lr;

  // band level from the registered product
  logic [48:0] lvl;
  level_t      band_val;
  always_comb begin
    lvl = {1'b0, ref_r} + {1'b0, prod_r[63:16]};
    if (selling_r) begin
      band_val = prod_r[63:32];
    end else if (lvl[48]) begin
      band_val = '1;
    end else begin
      band_val = lvl[47:16];
    end
  end

  logic in_acc;
  logic out_free;
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_chan.price == '0) ? S_MBAND : S_MAVG;
        end
      end
      S_MAVG:  state_nxt = S_DSET;
      S_DSET:  state_nxt = S_DIV;
      S_DIV: begin
        if (div_cnt_r == 6'd1) begin
          state_nxt = div_wt_r ? S_MBAND : S_UPD;
        end
      end
      S_UPD:   state_nxt = warm_r ? S_MBAND : S_MREF;
      S_MREF:  state_nxt = S_TEST;
      S_TEST: begin
        if (!selling_r && buy_hit && lr != '0 && wd < lr) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_MBAND;
        end
      end
      S_MBAND: state_nxt = S_BAND;
      S_BAND: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and series state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= DAYS_MIN;
      buy_band_r  <= BAND_RESET;
      sell_band_r <= BAND_RESET;
      selling_r   <= 1'b1;
      average_r   <= '0;
      warm_cnt_r  <= '0;
      ref_r       <= '0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
      div_wt_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_WINDOW: window_r    <= pwdata[DAYS_W-1:0];
          REG_BUY:    buy_band_r  <= pwdata[BAND_W-1:0];
          REG_SELL:   sell_band_r <= pwdata[BAND_W-1:0];
          default:    ;
        endcase
      end

      // divider control
      if (state_r == S_DSET) begin
        div_cnt_r <= AVG_DIV_STEPS;
        div_wt_r  <= 1'b0;
      end else if (state_r == S_TEST) begin
        div_cnt_r <= WT_DIV_STEPS;
        div_wt_r  <= 1'b1;
      end else if (state_r == S_DIV) begin
        div_cnt_r <= div_cnt_r - 6'd1;
      end

      // average and warm-up update
      if (state_r == S_UPD) begin
        average_r <= quo_r;
        if (warm_r) begin
          warm_cnt_r <= warm_cnt_r + 7'd1;
          ref_r      <= quo_r;
        end else begin
          ref_r <= ref_track;
        end
      end

      // crossover: switch mode and restart the reference
      if (state_r == S_TEST) begin
        if (selling_r ? sell_hit : buy_hit) begin
          ref_r     <= average_r;
          selling_r <= !selling_r;
        end
      end

      // output register
      if (state_r == S_BAND && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      price_r <= in_chan.price;
      warm_r  <= warm_cnt_r < days_eff;
      act_r   <= ACT_NONE;
      wt_r    <= '0;
    end

    if (state_r == S_MAVG || state_r == S_MREF || state_r == S_MBAND) begin
      prod_r <= mul_p[63:0];
    end

    if (state_r == S_DSET) begin
      rem_r <= {41'd0, num[55:48]};
      quo_r <= num[47:0];
      dvs_r <= warm_r ? {42'd0, 7'(warm_cnt_r + 7'd1)} : {42'd0, days_eff};
    end else if (state_r == S_DIV) begin
      rem_r <= rem_step;
      quo_r <= quo_step;
      if (div_cnt_r == 6'd1 && div_wt_r) begin
        wt_r <= quo_step[WEIGHT_W-1:0];
      end
    end else if (state_r == S_TEST) begin
      rem_r <= wd;
      quo_r <= '0;
      dvs_r <= lr;
    end

    // action and the saturated weight cases
    if (state_r == S_TEST) begin
      if (selling_r) begin
        if (sell_hit) begin
          act_r <= ACT_SELL;
        end
      end else if (buy_hit) begin
        act_r <= ACT_BUY;
        if (lr == '0) begin
          wt_r <= (wd != '0) ? '1 : '0;
        end else if (wd >= lr) begin
          wt_r <= '1;
        end
      end
    end

    if (state_r == S_BAND && out_free) begin
      out_action_r <= act_r;
      out_weight_r <= wt_r;
      out_level_r  <= band_val;
    end
  end

  assign in_chan.ready       = state_r == S_IDLE;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.action     = out_action_r;
  assign out_chan.buy_weight = out_weight_r;
  assign out_chan.band_level = out_level_r;

  // divider remainder stays below a nonzero divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (rem_r < dvs_r) && (dvs_r != '0))
    else $error("divider remainder not below divisor");

  // warm-up count never passes the largest window
  a_warm_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    warm_cnt_r <= DAYS_MAX)
    else $error("warm-up count beyond window");

  // a weight is only reported with a buy
  a_weight_buy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_action_r != ACT_BUY |-> out_weight_r == '0)
    else $error("buy weight without buy");

  // a buy leaves the block in sell mode, a sell in buy mode
  a_mode_flip: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BAND && out_free |=>
      (out_action_r != ACT_BUY || selling_r) && (out_action_r != ACT_SELL || !selling_r))
    else $error("mode does not match reported action");

  // no word is taken while the sequencer is busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_chan.ready)
    else $error("input ready while busy");

endmodule

// ----- bench/moving_average_band_signal_top_tb.sv -----
// ---------------------------------------------------------------------------
// moving_average_band_signal_top_tb
// self-checking bench for the moving average band crossover block
// ---------------------------------------------------------------------------
// prices enter on the input channel with random gaps, and results leave
// under random stalls. a local model of the average, the trailing reference
// and the band logic predicts every result word, and each word is compared
// field by field as it leaves the block. a short directed table comes
// first. random price walks follow under several window and band settings,
// which are written over apb and read back.
// ---------------------------------------------------------------------------
module moving_average_band_signal_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mab_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_WORDS  = 240;
  localparam int DRAIN_CYCLES = 100;
  localparam int PRINT_CAP    = 40;
  localparam int DIR_ROWS     = 9;
  localparam int NUM_PHASES   = 8;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    action_t action;
    weight_t weight;
    level_t  level;
  } signal_t;

  typedef struct packed {
    price_t  price;
    bit      typed;
    signal_t want;
  } price_word_t;

  typedef struct packed {
    price_t     price;
    logic [4:0] reps;
    bit         typed;
    signal_t    want;
  } dir_row_t;

  typedef struct packed {
    days_t      win;
    band_t      buy;
    band_t      sell;
    bit         rand_win;
    bit         rand_bands;
    logic [6:0] send_idle;
    logic [6:0] recv_idle;
    bit         hold;
  } phase_t;

  // directed prices under the reset settings (window 20, bands about 1%)
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // nothing quoted yet: sell mode, zero reference, zero level
    '{32'h0000_0000, 5'd1,  1'b1, '{ACT_NONE, 16'd0, 32'd0}},
    // warm-up opens with the largest and smallest prices
    '{32'hFFFF_FFFF, 5'd1,  1'b0, '0},
    '{32'h0000_0001, 5'd1,  1'b0, '0},
    // rest of the warm-up
    '{32'h0010_0000, 5'd18, 1'b0, '0},
    // deep drop under the trailing max: sell
    '{32'h0100_0000, 5'd1,  1'b0, '0},
    // no quote while waiting to buy
    '{32'h0000_0000, 5'd1,  1'b0, '0},
    // far over the trailing min: buy with saturated weight
    '{32'hFFFF_FFFF, 5'd1,  1'b0, '0},
    // tiny price: sell again
    '{32'h0000_8000, 5'd1,  1'b0, '0},
    // modest rise over the buy level: fractional weight
    '{32'h1C00_0000, 5'd1,  1'b0, '0}
  };

  // register settings and idling per random phase
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{7'd20,  16'd655,  16'd655,  1'b0, 1'b0, 7'd12, 7'd83, 1'b0},
    // longer window resumes warm-up where the short one stopped
    '{7'd120, 16'd0,    16'd0,    1'b0, 1'b0, 7'd12, 7'd83, 1'b1},
    // under the clamp after a full warm-up, widest bands
    '{7'd7,   16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 7'd12, 7'd83, 1'b0},
    // over the clamp
    '{7'd127, 16'd3277, 16'd6554, 1'b0, 1'b0, 7'd83, 7'd12, 1'b0},
    '{7'd20,  16'd1,    16'd1,    1'b0, 1'b0, 7'd83, 7'd12, 1'b0},
    '{7'd45,  16'd0,    16'd0,    1'b0, 1'b1, 7'd83, 7'd12, 1'b0},
    '{7'd100, 16'd1310, 16'd1310, 1'b0, 1'b0, 7'd0,  7'd0,  1'b1},
    '{7'd0,   16'd0,    16'd0,    1'b1, 1'b1, 7'd0,  7'd0,  1'b0}
  };

  logic   clk = 1'b0;
  logic   rst_n;
  logic   psel;
  logic   penable;
  logic   pwrite;
  addr_t  paddr;
  data_t  pwdata;
  data_t  prdata;
  logic   pready;

  mab_in_if  in_ch ();
  mab_out_if out_ch ();

  moving_average_band_signal_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow registers and signal state
  days_t win_cfg   = DAYS_MIN;
  band_t buy_cfg   = BAND_RESET;
  band_t sell_cfg  = BAND_RESET;
  bit    sell_mode = 1'b1;
  avg_t  avg_st    = '0;
  avg_t  ref_st    = '0;
  days_t warm_cnt  = '0;

  price_word_t pending_prices [$];
  signal_t     expected_signals [$];

  price_t walk_px = 32'h0100_0000;
  bit     walk_up = 1'b1;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;

  int cycle_count     = 0;
  int mismatch_count  = 0;
  int prices_taken    = 0;
  int words_checked   = 0;
  int sell_count      = 0;
  int buy_count       = 0;
  int configs_applied = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // next signal word for one price; advances the average and reference
  function automatic signal_t predict_signal(input price_t q);
    logic [63:0] days;
    logic [63:0] qa;
    logic [63:0] qx;
    logic [63:0] avg;
    logic [63:0] tb;
    logic [63:0] lr;
    logic [63:0] diff;
    logic [63:0] wt;
    logic [63:0] lvl;
    bit          hit;
    signal_t     res;
    res  = '{ACT_NONE, 16'd0, 32'd0};
    days = 64'(win_cfg);
    if (days < 64'(DAYS_MIN)) days = 64'(DAYS_MIN);
    if (days > 64'(DAYS_MAX)) days = 64'(DAYS_MAX);
    if (q != '0) begin
      qa = 64'(q) << AVG_SHIFT;
      qx = 64'(q) << 32;
      if (64'(warm_cnt) < days) begin
        // warm-up: cumulative mean, reference follows it
        avg      = (64'(avg_st) * 64'(warm_cnt) + qa) / (64'(warm_cnt) + 64'd1);
        avg_st   = avg[AVG_W-1:0];
        warm_cnt = warm_cnt + 7'd1;
        ref_st   = avg_st;
      end else begin
        avg    = (64'(avg_st) * (days - 64'd1) + qa) / days;
        avg_st = avg[AVG_W-1:0];
        if (sell_mode) begin
          // trailing max, sell on a drop through the band
          if (avg_st > ref_st) ref_st = avg_st;
          if (qx <= 64'(ref_st) * (64'd65536 - 64'(sell_cfg))) begin
            ref_st     = avg_st;
            sell_mode  = 1'b0;
            res.action = ACT_SELL;
          end
        end else begin
          // trailing min, buy on a rise through the band
          if (avg_st < ref_st) ref_st = avg_st;
          tb  = 64'(ref_st) * 64'(buy_cfg);
          hit = (tb <= qx) && ((qx - tb) >= (64'(ref_st) << 16));
          if (hit) begin
            lr   = 64'(ref_st) + (tb >> 16);
            diff = qa - lr;
            if (lr == 64'd0) begin
              wt = (diff != 64'd0) ? 64'd65535 : 64'd0;
            end else if (diff >= lr) begin
              wt = 64'd65535;
            end else begin
              wt = (diff << 16) / lr;
              if (wt > 64'd65535) wt = 64'd65535;
            end
            res.weight = wt[WEIGHT_W-1:0];
            ref_st     = avg_st;
            sell_mode  = 1'b1;
            res.action = ACT_BUY;
          end
        end
      end
    end
    // band level after the step
    if (sell_mode) begin
      lvl = (64'(ref_st) * (64'd65536 - 64'(sell_cfg))) >> 32;
    end else begin
      lvl = (64'(ref_st) + ((64'(ref_st) * 64'(buy_cfg)) >> 16)) >> AVG_SHIFT;
      if (lvl > 64'hFFFF_FFFF) lvl = 64'hFFFF_FFFF;
    end
    res.level = lvl[PRICE_W-1:0];
    return res;
  endfunction

  // random walk with trends and jumps, plus no-quote and stray words
  function automatic price_t next_price();
    int unsigned pick;
    price_t      step;
    pick = $urandom_range(99);
    if (pick < 4) return '0;
    if (pick < 6) return price_t'($urandom());
    if (pick == 6) return ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
    if (pick < 9) walk_px = price_t'($urandom_range(32'h4000_0000, 32'h0001_0000));
    if ($urandom_range(11) == 0) walk_up = !walk_up;
    step = price_t'($urandom_range(walk_px >> $urandom_range(7, 3)));
    if (walk_up) begin
      walk_px = walk_px + step;
    end else begin
      walk_px = walk_px - step;
    end
    if (walk_px < 32'h0001_0000) begin
      walk_px = 32'h0001_0000;
      walk_up = 1'b1;
    end
    if (walk_px > 32'hC000_0000) begin
      walk_px = 32'hC000_0000;
      walk_up = 1'b0;
    end
    return walk_px;
  endfunction

  // one apb transfer: setup cycle, then access until pready
  task automatic apb_access(input bit wr, input logic [1:0] idx, input data_t wdata,
                            output data_t rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx, input data_t want);
    data_t rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== want) begin
      report_mismatch($sformatf("register %0d reads %h, expected %h", idx, rd, want));
    end
  endtask

  // write all three registers with junk in the unused bits, then read back
  task automatic set_config(input days_t win, input band_t buy, input band_t sell);
    data_t junk;
    data_t rd;
    junk = $urandom();
    apb_access(1'b1, REG_WINDOW, {junk[DATA_W-1:DAYS_W], win}, rd);
    junk = $urandom();
    apb_access(1'b1, REG_BUY, {junk[DATA_W-1:BAND_W], buy}, rd);
    junk = $urandom();
    apb_access(1'b1, REG_SELL, {junk[DATA_W-1:BAND_W], sell}, rd);
    win_cfg  = win;
    buy_cfg  = buy;
    sell_cfg = sell;
    check_reg(REG_WINDOW, data_t'(win));
    check_reg(REG_BUY, data_t'(buy));
    check_reg(REG_SELL, data_t'(sell));
    configs_applied++;
  endtask

  // offer queued prices; a word stays up until it is taken
  task automatic drive_prices();
    bit      held;
    signal_t pred;
    held = 1'b0;
    while (pending_prices.size() != 0) begin
      @(negedge clk);
      if (!held) begin
        if ($urandom_range(99) < send_idle_pct) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.price <= pending_prices[0].price;
          held = 1'b1;
        end
      end
      @(posedge clk);
      if (held && in_ch.ready) begin
        pred = predict_signal(pending_prices[0].price);
        if (pred.action == ACT_SELL) sell_count++;
        if (pred.action == ACT_BUY) buy_count++;
        expected_signals.push_back(pending_prices[0].typed ? pending_prices[0].want : pred);
        void'(pending_prices.pop_front());
        prices_taken++;
        held = 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // result side: long hold-off when asked, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin : result_check
    signal_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_signals.size() == 0) begin
        report_mismatch($sformatf("unexpected word: action %0d weight %h level %h",
                                  out_ch.action, out_ch.buy_weight, out_ch.band_level));
      end else begin
        want = expected_signals.pop_front();
        words_checked++;
        if (out_ch.action !== want.action) begin
          report_mismatch($sformatf("word %0d action %0d, expected %0d",
                                    words_checked, out_ch.action, want.action));
        end
        if (out_ch.buy_weight !== want.weight) begin
          report_mismatch($sformatf("word %0d buy_weight %h, expected %h",
                                    words_checked, out_ch.buy_weight, want.weight));
        end
        if (out_ch.band_level !== want.level) begin
          report_mismatch($sformatf("word %0d band_level %h, expected %h",
                                    words_checked, out_ch.band_level, want.level));
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d words outstanding", cycle_count,
               expected_signals.size());
      $display("moving_average_band_signal_top verification failed");
      $finish;
    end
  end

  initial begin
    phase_t ph;
    days_t  win;
    band_t  bb;
    band_t  sb;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.price  = '0;
    out_ch.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    send_idle_pct = PHASES[0].send_idle;
    recv_idle_pct = PHASES[0].recv_idle;

    // reset
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register defaults
    check_reg(REG_WINDOW, data_t'(DAYS_MIN));
    check_reg(REG_BUY, data_t'(BAND_RESET));
    check_reg(REG_SELL, data_t'(BAND_RESET));

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      repeat (DIR_TABLE[i].reps) begin
        pending_prices.push_back('{DIR_TABLE[i].price, DIR_TABLE[i].typed, DIR_TABLE[i].want});
      end
    end
    drive_prices();

    // random phases, each under its own settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      ph = PHASES[p];
      while (expected_signals.size() != 0) @(posedge clk);
      win = ph.rand_win ? days_t'($urandom_range(127)) : ph.win;
      bb  = ph.rand_bands ? band_t'($urandom_range(16'hFFFF)) : ph.buy;
      sb  = ph.rand_bands ? band_t'($urandom_range(16'hFFFF)) : ph.sell;
      set_config(win, bb, sb);
      @(posedge clk);
      send_idle_pct = ph.send_idle;
      recv_idle_pct = ph.recv_idle;
      if (ph.hold) hold_left = HOLD_CYCLES;
      repeat (PHASE_WORDS) begin
        pending_prices.push_back('{next_price(), 1'b0, '0});
      end
      drive_prices();
    end

    // drain
    while (expected_signals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d prices under %0d register settings: %0d sells, %0d buys",
             prices_taken, configs_applied + 1, sell_count, buy_count);
    $display("%0d result words compared, %0d mismatches", words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("moving_average_band_signal_top verification clean");
    end else begin
      $display("moving_average_band_signal_top verification failed");
    end
    $finish;
  end

endmodule
